@@ sv/assert_macros.svh @@
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge out of reset
`define AST_HOLDS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define AST_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define AST_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/pfa_pkg.sv @@
package pfa_pkg;

    // fixed geometry
    localparam int ADDR_BITS  = 52;
    localparam int PAGE_SHIFT = 12;
    localparam int PAGE_BYTES = 4096;
    localparam int PN_BITS    = ADDR_BITS - PAGE_SHIFT;
    localparam int LOW_BITS   = 33;
    localparam int STATUS_W   = 3;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 2;

    // default sizes
    localparam int MAX_RANGES_DEF = 8;
    localparam int FREE_DEPTH_DEF = 1024;

    localparam logic [ADDR_BITS-1:0] ADDR_MAX = {ADDR_BITS{1'b1}};
    localparam logic [ADDR_BITS-1:0] FOUR_GIB = ADDR_BITS'(64'h1_0000_0000);

    // request modes
    localparam logic [MODE_W-1:0] MODE_ALLOC   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FREE    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RESERVE = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] ST_OOM        = 3'd1;
    localparam logic [STATUS_W-1:0] ST_REFUSED    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_TABLE_FULL = 3'd3;
    localparam logic [STATUS_W-1:0] ST_QUEUE_FULL = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRONT_START = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_TOP     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MEMORY_TOP  = 2'd2;

    typedef struct packed {
        logic [MODE_W-1:0]    mode;
        logic [ADDR_BITS-1:0] address;
        logic [ADDR_BITS-1:0] size;
    } t_req;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [ADDR_BITS-1:0] page_address;
        logic [ADDR_BITS-1:0] used_bytes;
    } t_rsp;

endpackage

@@ sv/page_frame_allocator.sv @@
// channel   | direction | handshake            | payload
// ----------+-----------+----------------------+--------------------------
// request   | in        | i_valid / o_stall    | i_data  (pfa_pkg::t_req)
// result    | out       | o_valid / i_stall    | o_data  (pfa_pkg::t_rsp)
// config    | in        | i_cfg_wr_en          | i_cfg_index, i_cfg_wdata
//
// free, reserve, freed-queue allocate: S_FREE, S_RSV or S_POP, then S_DONE; unused mode goes straight to S_DONE
// allocate from the front: S_ALLOC checks the top (a failure goes straight to S_DONE), then S_SCAN makes
//   passes over R ranges (1 to R + 1 passes), one range compare per cycle in a shared compare unit
// synchronous active-low reset clears control state; queue and range table need no clear
// a finished result waits in the output register while i_stall is high; a new request
//   may be taken meanwhile and holds in the done state until the register frees

`include "assert_macros.svh"

module page_frame_allocator #(
    parameter int MAX_RANGES = pfa_pkg::MAX_RANGES_DEF,
    parameter int FREE_DEPTH = pfa_pkg::FREE_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  pfa_pkg::t_req                  i_data,
    output logic                           o_valid,
    input  logic                           i_stall,
    output pfa_pkg::t_rsp                  o_data,
    input  logic                           i_cfg_wr_en,
    input  logic [pfa_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [pfa_pkg::ADDR_BITS-1:0]  i_cfg_wdata
);
    import pfa_pkg::*;

    localparam int PTR_W  = $clog2(FREE_DEPTH);
    localparam int CNT_W  = $clog2(FREE_DEPTH + 1);
    localparam int RCNT_W = $clog2(MAX_RANGES + 1);
    localparam int RIDX_W = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
    localparam int SUM_W  = ADDR_BITS + 2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_POP,
        S_ALLOC,
        S_SCAN,
        S_FREE,
        S_RSV,
        S_DONE
    } t_state;

    t_state r_state;

    // configuration and allocator state
    logic [ADDR_BITS-1:0] r_front;
    logic [LOW_BITS-1:0]  r_low_top;
    logic [ADDR_BITS-1:0] r_mem_top;
    logic [ADDR_BITS-1:0] r_bytes;
    logic [PTR_W-1:0]     r_free_head;
    logic [PTR_W-1:0]     r_free_tail;
    logic [CNT_W-1:0]     r_free_count;
    logic [RCNT_W-1:0]    r_res_used;
    logic [PN_BITS-1:0]   r_res_lo [MAX_RANGES];
    logic [PN_BITS-1:0]   r_res_hi [MAX_RANGES];

    // sequencer working registers
    logic [RCNT_W-1:0]    r_scan;
    logic                 r_moved;
    logic [ADDR_BITS-1:0] r_addr;
    logic [ADDR_BITS-1:0] r_size;
    logic [STATUS_W-1:0]  r_status;
    logic [ADDR_BITS-1:0] r_page;
    logic                 r_out_valid;
    t_rsp                 r_out;

    // freed page queue
    logic [PN_BITS-1:0]   r_fifo_mem [FREE_DEPTH];
    logic [PN_BITS-1:0]   r_pop_data;

    logic [ADDR_BITS-1:0] n_front_inc;
    logic [ADDR_BITS-1:0] n_bytes_inc;
    logic [ADDR_BITS-1:0] n_bytes_dec;
    logic [PTR_W-1:0]     n_head_next;
    logic [PTR_W-1:0]     n_tail_next;
    logic [LOW_BITS-1:0]  n_low_lim;
    logic                 n_jump;
    logic [RIDX_W-1:0]    n_scan_idx;
    logic [ADDR_BITS-1:0] n_lo_addr;
    logic [ADDR_BITS-1:0] n_hi_addr;
    logic                 n_hit;
    logic [SUM_W-1:0]     n_end_sum;
    logic [SUM_W-PAGE_SHIFT-1:0] n_end_pn_full;
    logic [PN_BITS-1:0]   n_end_pn;
    logic                 n_push;

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    // saturating page steps
    assign n_front_inc = (r_front > ADDR_MAX - ADDR_BITS'(PAGE_BYTES)) ?
                         ADDR_MAX : r_front + ADDR_BITS'(PAGE_BYTES);
    assign n_bytes_inc = (r_bytes > ADDR_MAX - ADDR_BITS'(PAGE_BYTES)) ?
                         ADDR_MAX : r_bytes + ADDR_BITS'(PAGE_BYTES);
    assign n_bytes_dec = (r_bytes < ADDR_BITS'(PAGE_BYTES)) ?
                         '0 : r_bytes - ADDR_BITS'(PAGE_BYTES);

    // ring pointer wrap
    assign n_head_next = (r_free_head == PTR_W'(FREE_DEPTH - 1)) ? '0 : r_free_head + 1'b1;
    assign n_tail_next = (r_free_tail == PTR_W'(FREE_DEPTH - 1)) ? '0 : r_free_tail + 1'b1;

    // jump to 4 GiB once the front reaches the last page below the low top
    assign n_low_lim = r_low_top - LOW_BITS'(PAGE_BYTES);
    assign n_jump    = (r_low_top >= LOW_BITS'(PAGE_BYTES))
                    && (r_front >= ADDR_BITS'(n_low_lim))
                    && (r_front < FOUR_GIB);

    // shared range compare unit, one table entry per cycle
    assign n_scan_idx = r_scan[RIDX_W-1:0];
    assign n_lo_addr  = {r_res_lo[n_scan_idx], PAGE_SHIFT'(0)};
    assign n_hi_addr  = {r_res_hi[n_scan_idx], PAGE_SHIFT'(0)};
    assign n_hit      = (r_front >= n_lo_addr) && (r_front < n_hi_addr);

    // reserve end rounded up to a page, saturated
    assign n_end_sum     = SUM_W'(r_addr) + SUM_W'(r_size) + SUM_W'(PAGE_BYTES - 1);
    assign n_end_pn_full = n_end_sum[SUM_W-1:PAGE_SHIFT];
    assign n_end_pn      = (n_end_pn_full > (SUM_W-PAGE_SHIFT)'({PN_BITS{1'b1}})) ?
                           {PN_BITS{1'b1}} : n_end_pn_full[PN_BITS-1:0];

    // free accepted into the queue
    assign n_push = (r_state == S_FREE) && !(r_addr > r_front)
                 && (r_free_count < CNT_W'(FREE_DEPTH));

    // queue storage: one write, one registered read at the head
    always_ff @(posedge i_clk) begin
        if (n_push) begin
            r_fifo_mem[r_free_tail] <= r_addr[ADDR_BITS-1:PAGE_SHIFT];
        end
        r_pop_data <= r_fifo_mem[r_free_head];
    end

    // sequencer, allocator state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_front      <= '0;
            r_low_top    <= '0;
            r_mem_top    <= '0;
            r_bytes      <= '0;
            r_free_head  <= '0;
            r_free_tail  <= '0;
            r_free_count <= '0;
            r_res_used   <= '0;
            r_scan       <= '0;
            r_moved      <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            // configuration writes
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    CFG_FRONT_START: r_front   <= i_cfg_wdata;
                    CFG_LOW_TOP:     r_low_top <= i_cfg_wdata[LOW_BITS-1:0];
                    CFG_MEMORY_TOP:  r_mem_top <= i_cfg_wdata;
                    default: ;
                endcase
            end

            // result transaction taken downstream; the done state reloads on its own
            if (r_out_valid && !i_stall && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_addr   <= i_data.address;
                        r_size   <= i_data.size;
                        r_status <= ST_OK;
                        r_page   <= '0;
                        unique case (i_data.mode)
                            MODE_ALLOC:   r_state <= (r_free_count != '0) ? S_POP : S_ALLOC;
                            MODE_FREE:    r_state <= S_FREE;
                            MODE_RESERVE: r_state <= S_RSV;
                            default:      r_state <= S_DONE;
                        endcase
                    end
                end

                // oldest freed page
                S_POP: begin
                    r_page       <= {r_pop_data, PAGE_SHIFT'(0)};
                    r_free_head  <= n_head_next;
                    r_free_count <= r_free_count - 1'b1;
                    r_bytes      <= n_bytes_inc;
                    r_state      <= S_DONE;
                end

                // top check and low-memory jump
                S_ALLOC: begin
                    r_scan  <= '0;
                    r_moved <= 1'b0;
                    if (r_front >= r_mem_top) begin
                        r_status <= ST_OOM;
                        r_state  <= S_DONE;
                    end else if (n_jump) begin
                        r_front <= FOUR_GIB;
                        if (FOUR_GIB >= r_mem_top) begin
                            r_status <= ST_OOM;
                            r_state  <= S_DONE;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end else begin
                        r_state <= S_SCAN;
                    end
                end

                // step past reserved ranges until a pass moves nothing
                S_SCAN: begin
                    if (r_scan < r_res_used) begin
                        if (n_hit) begin
                            r_front <= n_hi_addr;
                            r_moved <= 1'b1;
                        end
                        r_scan <= r_scan + 1'b1;
                    end else if (r_moved) begin
                        r_scan  <= '0;
                        r_moved <= 1'b0;
                    end else begin
                        if (r_front >= r_mem_top) begin
                            r_status <= ST_OOM;
                        end else begin
                            r_page  <= r_front;
                            r_front <= n_front_inc;
                            r_bytes <= n_bytes_inc;
                        end
                        r_state <= S_DONE;
                    end
                end

                S_FREE: begin
                    if (r_addr > r_front) begin
                        r_status <= ST_REFUSED;
                    end else if (r_free_count >= CNT_W'(FREE_DEPTH)) begin
                        r_status <= ST_QUEUE_FULL;
                    end else begin
                        r_free_tail  <= n_tail_next;
                        r_free_count <= r_free_count + 1'b1;
                        r_bytes      <= n_bytes_dec;
                    end
                    r_state <= S_DONE;
                end

                S_RSV: begin
                    if (r_res_used >= RCNT_W'(MAX_RANGES)) begin
                        r_status <= ST_TABLE_FULL;
                    end else begin
                        r_res_lo[r_res_used[RIDX_W-1:0]] <= r_addr[ADDR_BITS-1:PAGE_SHIFT];
                        r_res_hi[r_res_used[RIDX_W-1:0]] <= n_end_pn;
                        r_res_used <= r_res_used + 1'b1;
                    end
                    r_state <= S_DONE;
                end

                // load the output register once it is free
                S_DONE: begin
                    if (!r_out_valid || !i_stall) begin
                        r_out_valid        <= 1'b1;
                        r_out.status       <= r_status;
                        r_out.page_address <= r_page;
                        r_out.used_bytes   <= r_bytes;
                        r_state            <= S_IDLE;
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

    // checks
    `AST_HOLDS(a_free_count_bound, i_clk, i_rst_n, r_free_count <= CNT_W'(FREE_DEPTH), "freed page count above queue depth")
    `AST_HOLDS(a_range_count_bound, i_clk, i_rst_n, r_res_used <= RCNT_W'(MAX_RANGES), "reserved range count above table size")
    `AST_NEXT(a_front_monotonic, i_clk, i_rst_n, !i_cfg_wr_en, r_front >= $past(r_front), "allocation front moved backward")
    `AST_IMPL(a_oom_no_page, i_clk, i_rst_n, o_valid && (o_data.status != ST_OK), o_data.page_address == '0, "failed transaction carries a page")

endmodule

@@ tb/tb.sv @@
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pfa_pkg::*;

    // mode value the block defines no operation for
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    localparam int          CYCLE_LIMIT  = 1_000_000;
    localparam int          DRAIN_CYCLES = 100;
    localparam logic [63:0] PAGE_LEN     = 64'(PAGE_BYTES);
    localparam logic [63:0] ADDR_LIMIT   = 64'(ADDR_MAX);
    localparam logic [63:0] PN_LIMIT     = (64'd1 << PN_BITS) - 64'd1;
    localparam logic [63:0] FOUR_GIB_64  = 64'(FOUR_GIB);

    // fixed spots for the reserved ranges
    localparam logic [ADDR_BITS-1:0] PAGE        = 52'h1000;
    localparam logic [ADDR_BITS-1:0] REGION_BASE = 52'h10_0000;
    localparam logic [ADDR_BITS-1:0] EMPTY_SPOT  = 52'h20_0000;
    localparam logic [ADDR_BITS-1:0] LOW_TOP_2G  = 52'h8000_0000;

    typedef enum int {
        PACE_STEADY,
        PACE_SENDER_GAPS,
        PACE_RECEIVER_STALLS,
        PACE_BOTH_IDLE
    } pace_t;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_valid     = 1'b0;
    logic                 o_stall;
    t_req                 i_data      = '0;
    logic                 o_valid;
    logic                 i_stall     = 1'b0;
    t_rsp                 o_data;
    logic                 i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_FRONT_START;
    logic [ADDR_BITS-1:0] i_cfg_wdata = '0;

    page_frame_allocator uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_data      (o_data),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // allocator state as the testbench sees it
    logic [ADDR_BITS-1:0] reg_front_start = '0;
    logic [LOW_BITS-1:0]  reg_low_top     = '0;
    logic [ADDR_BITS-1:0] reg_memory_top  = '0;
    logic [ADDR_BITS-1:0] alloc_pos       = '0;
    logic [PN_BITS-1:0]   freed_pns[$];
    logic [PN_BITS-1:0]   range_lo_pn[MAX_RANGES_DEF];
    logic [PN_BITS-1:0]   range_hi_pn[MAX_RANGES_DEF];
    int                   range_count     = 0;
    logic [ADDR_BITS-1:0] bytes_held      = '0;

    // expected results in order, and pages handed out for later frees
    t_rsp                 pending_results[$];
    logic [ADDR_BITS-1:0] handed_pages[$];

    int send_gap_pct     = 0;
    int recv_stall_pct   = 0;
    int hold_request     = 0;
    int cycle_count      = 0;
    int fail_count       = 0;
    int requests_sent    = 0;
    int results_checked  = 0;
    int status_seen[8];

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("run stopped after %0d cycles with %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("page_frame_allocator: mismatch");
            $finish;
        end
    end

    // receiver stall, with an optional long hold-off counted here
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_request > 0) begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    // take the next page off the bump front
    function automatic bit carve_front(output logic [ADDR_BITS-1:0] page);
        bit          moved;
        logic [63:0] pos;
        logic [63:0] lo;
        logic [63:0] hi;
        page = '0;
        pos = 64'(alloc_pos);
        if (pos >= 64'(reg_memory_top))
            return 1'b0;
        // hop over the hole below 4 GiB
        if (64'(reg_low_top) >= PAGE_LEN && pos >= 64'(reg_low_top) - PAGE_LEN &&
            pos < FOUR_GIB_64) begin
            pos = FOUR_GIB_64;
            alloc_pos = pos[ADDR_BITS-1:0];
            if (pos >= 64'(reg_memory_top))
                return 1'b0;
        end
        // step past reserved ranges until a whole pass leaves the front alone
        moved = 1'b1;
        while (moved) begin
            moved = 1'b0;
            for (int i = 0; i < range_count; i++) begin
                lo = 64'(range_lo_pn[i]) << PAGE_SHIFT;
                hi = 64'(range_hi_pn[i]) << PAGE_SHIFT;
                if (pos >= lo && pos < hi) begin
                    pos = hi;
                    moved = 1'b1;
                end
            end
        end
        alloc_pos = pos[ADDR_BITS-1:0];
        if (pos >= 64'(reg_memory_top))
            return 1'b0;
        page = pos[ADDR_BITS-1:0];
        // front saturates at the top of the address space
        if (pos > ADDR_LIMIT - PAGE_LEN)
            alloc_pos = ADDR_MAX;
        else
            alloc_pos = ADDR_BITS'(pos + PAGE_LEN);
        return 1'b1;
    endfunction

    // apply one request to the allocator state and return its result
    function automatic t_rsp apply_request(t_req req);
        t_rsp                 rsp;
        logic [ADDR_BITS-1:0] page;
        logic [PN_BITS-1:0]   pn;
        logic [63:0]          end_pn;
        bit                   ok;
        rsp = '0;
        page = '0;
        rsp.status = ST_OK;
        case (req.mode)
            MODE_ALLOC: begin
                if (freed_pns.size() > 0) begin
                    pn = freed_pns.pop_front();
                    page = {pn, 12'h000};
                    ok = 1'b1;
                end else begin
                    ok = carve_front(page);
                end
                if (ok) begin
                    if (64'(bytes_held) > ADDR_LIMIT - PAGE_LEN)
                        bytes_held = ADDR_MAX;
                    else
                        bytes_held = ADDR_BITS'(64'(bytes_held) + PAGE_LEN);
                    handed_pages.push_back(page);
                end else begin
                    page = '0;
                    rsp.status = ST_OOM;
                end
            end
            MODE_FREE: begin
                if (req.address > alloc_pos) begin
                    rsp.status = ST_REFUSED;
                end else if (freed_pns.size() >= FREE_DEPTH_DEF) begin
                    rsp.status = ST_QUEUE_FULL;
                end else begin
                    freed_pns.push_back(req.address[ADDR_BITS-1:PAGE_SHIFT]);
                    if (64'(bytes_held) < PAGE_LEN)
                        bytes_held = '0;
                    else
                        bytes_held = ADDR_BITS'(64'(bytes_held) - PAGE_LEN);
                end
            end
            MODE_RESERVE: begin
                if (range_count >= MAX_RANGES_DEF) begin
                    rsp.status = ST_TABLE_FULL;
                end else begin
                    end_pn = (64'(req.address) + 64'(req.size) + PAGE_LEN - 64'd1) >> PAGE_SHIFT;
                    if (end_pn > PN_LIMIT)
                        end_pn = PN_LIMIT;
                    range_lo_pn[range_count] = req.address[ADDR_BITS-1:PAGE_SHIFT];
                    range_hi_pn[range_count] = end_pn[PN_BITS-1:0];
                    range_count++;
                end
            end
            default: begin
            end
        endcase
        rsp.page_address = page;
        rsp.used_bytes = bytes_held;
        status_seen[rsp.status]++;
        return rsp;
    endfunction

    function automatic t_req make_request(logic [MODE_W-1:0] mode,
                                          logic [ADDR_BITS-1:0] address,
                                          logic [ADDR_BITS-1:0] size);
        t_req req;
        req.mode = mode;
        req.address = address;
        req.size = size;
        return req;
    endfunction

    // random address with the extremes and a spread of magnitudes mixed in
    function automatic logic [ADDR_BITS-1:0] rand_addr();
        logic [63:0] r;
        r = {$urandom, $urandom};
        case ($urandom_range(7))
            0: return '0;
            1: return ADDR_MAX;
            2: return ADDR_BITS'(r >> $urandom_range(51));
            default: return r[ADDR_BITS-1:0];
        endcase
    endfunction

    // mostly allocations and frees of pages that can come back
    function automatic t_req random_request();
        t_req        req;
        int          pick;
        int          idx;
        logic [63:0] r;
        logic [63:0] span;
        req = make_request(MODE_ALLOC, rand_addr(), rand_addr());
        pick = $urandom_range(99);
        if (pick < 48) begin
            req.mode = MODE_ALLOC;
        end else if (pick < 83) begin
            req.mode = MODE_FREE;
            pick = $urandom_range(9);
            if (pick < 5 && handed_pages.size() > 0) begin
                idx = $urandom_range(handed_pages.size() - 1);
                req.address = handed_pages[idx];
                handed_pages.delete(idx);
                if ($urandom_range(3) == 0)
                    req.address[PAGE_SHIFT-1:0] = PAGE_SHIFT'($urandom_range(PAGE_BYTES - 1));
            end else if (pick < 8) begin
                r = {$urandom, $urandom};
                span = 64'(alloc_pos) + 64'd1;
                req.address = ADDR_BITS'(r % span);
            end
        end else if (pick < 93) begin
            req.mode = MODE_RESERVE;
        end else begin
            req.mode = MODE_UNUSED;
        end
        return req;
    endfunction

    // one request transaction; the result is predicted at acceptance
    task automatic send_request(t_req req);
        while ($urandom_range(99) < send_gap_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= req;
        do
            @(posedge i_clk);
        while (o_stall);
        pending_results.push_back(apply_request(req));
        requests_sent++;
        @(negedge i_clk);
    endtask

    // wait until every result is back, then let the block settle
    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending_results.size() > 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_registers(logic [ADDR_BITS-1:0] start,
                                   logic [ADDR_BITS-1:0] low_top,
                                   logic [ADDR_BITS-1:0] top);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= CFG_FRONT_START;
        i_cfg_wdata <= start;
        @(negedge i_clk);
        i_cfg_index <= CFG_LOW_TOP;
        i_cfg_wdata <= low_top;
        @(negedge i_clk);
        i_cfg_index <= CFG_MEMORY_TOP;
        i_cfg_wdata <= top;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        @(negedge i_clk);
        reg_front_start = start;
        alloc_pos = start;
        reg_low_top = low_top[LOW_BITS-1:0];
        reg_memory_top = top;
    endtask

    task automatic set_pace(pace_t pace);
        case (pace)
            PACE_SENDER_GAPS: begin
                send_gap_pct = 80;
                recv_stall_pct = 0;
            end
            PACE_RECEIVER_STALLS: begin
                send_gap_pct = 0;
                recv_stall_pct = 80;
            end
            PACE_BOTH_IDLE: begin
                send_gap_pct = 31;
                recv_stall_pct = 31;
            end
            default: begin
                send_gap_pct = 0;
                recv_stall_pct = 0;
            end
        endcase
    endtask

    // registers still at reset: nothing to hand out, free at the front, unused mode
    task automatic test_reset_defaults();
        send_request(make_request(MODE_ALLOC, '0, '0));
        send_request(make_request(MODE_FREE, '0, ADDR_MAX));
        send_request(make_request(MODE_ALLOC, ADDR_MAX, '0));
        send_request(make_request(MODE_FREE, 52'h1, '0));
        send_request(make_request(MODE_UNUSED, ADDR_MAX, ADDR_MAX));
        wait_drained();
    endtask

    // fill the range table, including an empty range and a saturated end
    task automatic test_range_table();
        write_registers(REGION_BASE, LOW_TOP_2G, ADDR_MAX);
        // two ranges listed out of order so the front needs a second pass
        send_request(make_request(MODE_RESERVE, REGION_BASE + 2 * PAGE, 2 * PAGE));
        send_request(make_request(MODE_RESERVE, REGION_BASE + 52'h123, 52'h1edd));
        send_request(make_request(MODE_RESERVE, EMPTY_SPOT, '0));
        send_request(make_request(MODE_RESERVE, FOUR_GIB, 3 * PAGE));
        send_request(make_request(MODE_RESERVE, ADDR_MAX - 52'h7fff, ADDR_MAX));
        send_request(make_request(MODE_RESERVE, LOW_TOP_2G, PAGE));
        send_request(make_request(MODE_RESERVE, 52'h3000_0000_0000, 52'h10_0000));
        send_request(make_request(MODE_RESERVE, '0, '0));
        send_request(make_request(MODE_RESERVE, 52'h5000, 52'h5000));
        wait_drained();
    endtask

    // front walks through chained ranges; unaligned free comes back page aligned
    task automatic test_range_skip();
        send_request(make_request(MODE_ALLOC, '0, '0));
        send_request(make_request(MODE_FREE, REGION_BASE + 4 * PAGE + 52'h345, '0));
        send_request(make_request(MODE_ALLOC, '0, '0));
        send_request(make_request(MODE_FREE, ADDR_MAX, '0));
        wait_drained();
        // ranges carry the front onto the memory top
        write_registers(REGION_BASE, LOW_TOP_2G, REGION_BASE + 4 * PAGE);
        send_request(make_request(MODE_ALLOC, '0, '0));
        wait_drained();
    endtask

    // jump from the last low page to 4 GiB, a jump onto the memory top, and a low top too small to jump
    task automatic test_low_memory_jump();
        write_registers(LOW_TOP_2G - PAGE, LOW_TOP_2G, ADDR_MAX);
        send_request(make_request(MODE_ALLOC, '0, '0));
        wait_drained();
        write_registers(LOW_TOP_2G - PAGE, LOW_TOP_2G, FOUR_GIB);
        send_request(make_request(MODE_ALLOC, '0, '0));
        wait_drained();
        write_registers(FOUR_GIB - PAGE, FOUR_GIB, ADDR_MAX);
        send_request(make_request(MODE_ALLOC, '0, '0));
        wait_drained();
        write_registers('0, 52'hfff, ADDR_MAX);
        send_request(make_request(MODE_ALLOC, '0, '0));
        wait_drained();
    endtask

    // top of the address space: front saturates, then free at the front
    task automatic test_top_of_memory();
        write_registers(ADDR_MAX - 52'h7fff, LOW_TOP_2G, ADDR_MAX);
        send_request(make_request(MODE_ALLOC, '0, '0));
        send_request(make_request(MODE_ALLOC, '0, '0));
        send_request(make_request(MODE_FREE, ADDR_MAX, '0));
        send_request(make_request(MODE_ALLOC, '0, '0));
        wait_drained();
    endtask

    task automatic test_random_traffic(pace_t pace, logic [ADDR_BITS-1:0] start,
                                       logic [ADDR_BITS-1:0] low_top,
                                       logic [ADDR_BITS-1:0] top, int count);
        wait_drained();
        write_registers(start, low_top, top);
        set_pace(pace);
        repeat (count) send_request(random_request());
        wait_drained();
    endtask

    // flood of frees while the receiver holds off: queue overflows, block backs up
    task automatic test_free_queue_backpressure();
        wait_drained();
        write_registers(ADDR_MAX, '0, ADDR_MAX);
        set_pace(PACE_STEADY);
        hold_request = 400;
        repeat (FREE_DEPTH_DEF + 16) send_request(make_request(MODE_FREE, rand_addr(), rand_addr()));
        repeat (30) send_request(make_request(MODE_ALLOC, rand_addr(), rand_addr()));
        set_pace(PACE_BOTH_IDLE);
        repeat (20) send_request(random_request());
        wait_drained();
    endtask

    task automatic report_field(string what, logic [ADDR_BITS-1:0] want,
                                logic [ADDR_BITS-1:0] got);
        fail_count++;
        $display("%0t: %s expected 0x%0h got 0x%0h", $time, what, want, got);
    endtask

    // compare each accepted result transaction with the oldest prediction
    always @(posedge i_clk) begin : check_results
        t_rsp want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                report_field("unexpected result, used_bytes", '0, o_data.used_bytes);
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                if (o_data.status !== want.status)
                    report_field("status", ADDR_BITS'(want.status), ADDR_BITS'(o_data.status));
                if (o_data.page_address !== want.page_address)
                    report_field("page_address", want.page_address, o_data.page_address);
                if (o_data.used_bytes !== want.used_bytes)
                    report_field("used_bytes", want.used_bytes, o_data.used_bytes);
            end
        end
    end

    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_defaults();
        test_range_table();
        test_range_skip();
        test_low_memory_jump();
        test_top_of_memory();
        test_random_traffic(PACE_STEADY, LOW_TOP_2G - 52'h10_0000, LOW_TOP_2G,
                            FOUR_GIB + 52'h10_0000, 140);
        test_random_traffic(PACE_SENDER_GAPS, REGION_BASE - 2 * PAGE, 52'hfff,
                            REGION_BASE + 64 * PAGE, 140);
        test_random_traffic(PACE_RECEIVER_STALLS, ADDR_MAX - 52'hf_ffff, FOUR_GIB,
                            ADDR_MAX, 140);
        test_random_traffic(PACE_BOTH_IDLE, rand_addr(), ADDR_BITS'($urandom),
                            rand_addr(), 140);
        test_free_queue_backpressure();

        repeat (DRAIN_CYCLES) @(negedge i_clk);
        $display("%0d requests sent, %0d results checked, %0d mismatches, %0d cycles",
                 requests_sent, results_checked, fail_count, cycle_count);
        $display("outcomes: %0d ok, %0d out of memory, %0d refused, %0d table full, %0d queue full",
                 status_seen[ST_OK], status_seen[ST_OOM], status_seen[ST_REFUSED],
                 status_seen[ST_TABLE_FULL], status_seen[ST_QUEUE_FULL]);
        if (fail_count == 0) begin
            $display("page_frame_allocator: match");
        end else begin
            $display("page_frame_allocator: mismatch");
        end
        $finish;
    end

endmodule
